[rtl/twcw_pkg.sv]
package twcw_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_START_ROW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_COL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END_ROW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END_COL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ATTR_BASE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TAB_CHAR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BS_CHAR    = 3'd6;

   localparam logic [7:0]  CH_NL    = 8'd10;
   localparam logic [7:0]  CH_CR    = 8'd13;
   localparam logic [7:0]  CH_SPACE = 8'd32;
   localparam logic [15:0] ATTR_RST = 16'h0700;

   // character class of the latched item
   localparam logic [2:0] CLS_READ  = 3'd0;
   localparam logic [2:0] CLS_NL    = 3'd1;
   localparam logic [2:0] CLS_CR    = 3'd2;
   localparam logic [2:0] CLS_TAB   = 3'd3;
   localparam logic [2:0] CLS_BS    = 3'd4;
   localparam logic [2:0] CLS_ZERO  = 3'd5;
   localparam logic [2:0] CLS_PRINT = 3'd6;

   // memory address source
   localparam logic [2:0] ADR_ITEM   = 3'd0;
   localparam logic [2:0] ADR_CUR    = 3'd1;
   localparam logic [2:0] ADR_CURM1  = 3'd2;
   localparam logic [2:0] ADR_SCAN   = 3'd3;
   localparam logic [2:0] ADR_SCANUP = 3'd4;
   localparam logic [2:0] ADR_BLANK  = 3'd5;
   localparam logic [2:0] ADR_CLEAR  = 3'd6;

   // write data source
   localparam logic [1:0] WD_ZERO  = 2'd0;
   localparam logic [1:0] WD_CHAR  = 2'd1;
   localparam logic [1:0] WD_BLANK = 2'd2;
   localparam logic [1:0] WD_COPY  = 2'd3;

   // cursor update
   localparam logic [2:0] CUR_HOLD  = 3'd0;
   localparam logic [2:0] CUR_NL    = 3'd1;
   localparam logic [2:0] CUR_CR    = 3'd2;
   localparam logic [2:0] CUR_TAB   = 3'd3;
   localparam logic [2:0] CUR_BS_UP = 3'd4;
   localparam logic [2:0] CUR_DEC   = 3'd5;
   localparam logic [2:0] CUR_INC   = 3'd6;
   localparam logic [2:0] CUR_POST  = 3'd7;

   // scroll index update
   localparam logic [2:0] IDX_HOLD   = 3'd0;
   localparam logic [2:0] IDX_INIT   = 3'd1;
   localparam logic [2:0] IDX_NEXTJ  = 3'd2;
   localparam logic [2:0] IDX_NEXTI  = 3'd3;
   localparam logic [2:0] IDX_BLINIT = 3'd4;

   typedef struct packed {
      logic       load_item;
      logic       load_rsp;
      logic       mem_rd;
      logic       mem_wr;
      logic [2:0] addr_sel;
      logic [1:0] wd_sel;
      logic [2:0] cur_op;
      logic [2:0] idx_op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] cls;
      logic       guard;
      logic       at_left;
      logic       scan_go;
      logic       blank_hit;
      logic       col_eq_end;
      logic       scroll_need;
      logic       i_live;
      logic       j_live;
      logic       clr_done;
      logic       rsp_free;
   } stat_type;

endpackage

[rtl/twcw_ram.sv]
module twcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/twcw_dpath.sv]
module twcw_dpath
   import twcw_pkg::*;
#(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic                 req_cmd,
   input  logic [7:0]           req_char_code,
   input  logic [10:0]          req_cell_addr,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [4:0]           rsp_cursor_row,
   output logic [6:0]           rsp_cursor_col,
   output logic [15:0]          rsp_cell_data,
   input  cmd_type              cmd,
   output stat_type             stat
);

   localparam int NCELLS  = ROWS * COLS;
   localparam int AW      = $clog2(NCELLS);
   localparam int AXW_RAW = $clog2(32 * COLS + 128);
   localparam int AXW     = (AXW_RAW > 11) ? AXW_RAW : 11;

   // configuration
   logic [4:0]  start_row_ff, end_row_ff;
   logic [6:0]  start_col_ff, end_col_ff;
   logic [15:0] attr_ff;
   logic [7:0]  tab_ff, bs_ff;

   // item, cursor, scroll indices
   logic        it_cmd_ff;
   logic [7:0]  it_char_ff;
   logic [10:0] it_addr_ff;
   logic [4:0]  row_ff, row_in;
   logic [6:0]  col_ff, col_in;
   logic [5:0]  i_ff, i_in;
   logic [6:0]  j_ff, j_in;
   logic [AW-1:0] clr_ff;
   logic        rd_ok_ff;

   logic        rsp_valid_ff;
   logic [4:0]  rsp_row_ff;
   logic [6:0]  rsp_col_ff;
   logic [15:0] rsp_data_ff;

   logic [AXW-1:0] a_cur, a_scan, a_blank, addr;
   logic           addr_ok;
   logic [15:0]    rdata, rd_val, wdata;
   logic [4:0]     row1;
   logic [6:0]     col1;
   logic           wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_row_ff <= 5'd0;
         start_col_ff <= 7'd0;
         end_row_ff   <= 5'd25;
         end_col_ff   <= 7'd55;
         attr_ff      <= ATTR_RST;
         tab_ff       <= 8'd9;
         bs_ff        <= 8'd8;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_START_ROW: start_row_ff <= csr_wdata[4:0];
            REG_START_COL: start_col_ff <= csr_wdata[6:0];
            REG_END_ROW:   end_row_ff   <= csr_wdata[4:0];
            REG_END_COL:   end_col_ff   <= csr_wdata[6:0];
            REG_ATTR_BASE: attr_ff      <= csr_wdata;
            REG_TAB_CHAR:  tab_ff       <= csr_wdata[7:0];
            REG_BS_CHAR:   bs_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         it_cmd_ff  <= req_cmd;
         it_char_ff <= req_char_code;
         it_addr_ff <= req_cell_addr;
      end
   end

   // address arithmetic, row*COLS is a constant multiply
   assign a_cur   = AXW'(row_ff) * AXW'(COLS) + AXW'(col_ff);
   assign a_scan  = AXW'(i_ff) * AXW'(COLS) + AXW'(j_ff);
   assign a_blank = AXW'(row_ff) * AXW'(COLS) + AXW'(j_ff);

   always_comb begin
      unique case (cmd.addr_sel)
         ADR_ITEM:   addr = AXW'(it_addr_ff);
         ADR_CUR:    addr = a_cur;
         ADR_CURM1:  addr = a_cur - AXW'(1);
         ADR_SCAN:   addr = a_scan;
         ADR_SCANUP: addr = a_scan - AXW'(COLS);
         ADR_BLANK:  addr = a_blank;
         ADR_CLEAR:  addr = AXW'(clr_ff);
         default:    addr = AXW'(clr_ff);
      endcase
   end
   assign addr_ok = (addr < AXW'(NCELLS));

   assign rd_val = rd_ok_ff ? rdata : 16'd0;

   always_comb begin
      unique case (cmd.wd_sel)
         WD_ZERO:  wdata = 16'd0;
         WD_CHAR:  wdata = attr_ff + {8'd0, it_char_ff};
         WD_BLANK: wdata = attr_ff + {8'd0, CH_SPACE};
         WD_COPY:  wdata = rd_val;
         default:  wdata = 16'd0;
      endcase
   end

   twcw_ram #(.WIDTH(16), .DEPTH(NCELLS)) u_ram (
      .clock (clock),
      .en    ((cmd.mem_rd || cmd.mem_wr) && addr_ok),
      .we    (cmd.mem_wr),
      .addr  (addr[AW-1:0]),
      .wdata (wdata),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_ok_ff <= addr_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.mem_wr && cmd.addr_sel == ADR_CLEAR) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // wrap at the right edge, then clamp on scroll
   assign wrap = (col_ff >= end_col_ff);
   assign col1 = wrap ? start_col_ff : col_ff;
   assign row1 = wrap ? row_ff + 5'd1 : row_ff;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      unique case (cmd.cur_op)
         CUR_HOLD: ;
         CUR_NL: begin
            col_in = start_col_ff;
            row_in = row_ff + 5'd1;
         end
         CUR_CR:    col_in = start_col_ff;
         CUR_TAB:   col_in = {col_ff[6:2] + 5'd1, 2'b00};
         CUR_BS_UP: begin
            row_in = row_ff - 5'd1;
            col_in = end_col_ff;
         end
         CUR_DEC:   col_in = col_ff - 7'd1;
         CUR_INC:   col_in = col_ff + 7'd1;
         CUR_POST: begin
            if (row1 >= end_row_ff) begin
               row_in = end_row_ff - 5'd1;
               col_in = start_col_ff;
            end else begin
               row_in = row1;
               col_in = col1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      unique case (cmd.idx_op)
         IDX_HOLD: ;
         IDX_INIT: begin
            i_in = {1'b0, start_row_ff} + 6'd2;
            j_in = start_col_ff;
         end
         IDX_NEXTJ: j_in = j_ff + 7'd1;
         IDX_NEXTI: begin
            i_in = i_ff + 6'd1;
            j_in = start_col_ff;
         end
         IDX_BLINIT: j_in = start_col_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 5'd0;
         col_ff <= 7'd0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= col_ff;
         rsp_data_ff <= it_cmd_ff ? rd_val : 16'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_data  = rsp_data_ff;

   always_comb begin
      if (it_cmd_ff) begin
         stat.cls = CLS_READ;
      end else begin
         priority if (it_char_ff == CH_NL) stat.cls = CLS_NL;
         else if (it_char_ff == CH_CR)    stat.cls = CLS_CR;
         else if (it_char_ff == tab_ff)   stat.cls = CLS_TAB;
         else if (it_char_ff == bs_ff)    stat.cls = CLS_BS;
         else if (it_char_ff == 8'd0)     stat.cls = CLS_ZERO;
         else                             stat.cls = CLS_PRINT;
      end
   end

   assign stat.guard       = (col_ff == start_col_ff) && (row_ff == start_row_ff + 5'd1);
   assign stat.at_left     = (col_ff == start_col_ff);
   assign stat.scan_go     = (col_ff > start_col_ff);
   assign stat.blank_hit   = rd_ok_ff && (rdata[7:0] == CH_SPACE);
   assign stat.col_eq_end  = (col_ff == end_col_ff);
   assign stat.scroll_need = (row1 >= end_row_ff);
   assign stat.i_live      = (i_ff < {1'b0, end_row_ff});
   assign stat.j_live      = (j_ff < end_col_ff);
   assign stat.clr_done    = (clr_ff == AW'(NCELLS - 1));
   assign stat.rsp_free    = !rsp_valid_ff || !rsp_stall;

endmodule

[rtl/twcw_ctrl.sv]
module twcw_ctrl
   import twcw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_BS_SCAN = 4'd3;
   localparam logic [3:0] S_BS_WAIT = 4'd4;
   localparam logic [3:0] S_BS_FIX  = 4'd5;
   localparam logic [3:0] S_BS_WR   = 4'd6;
   localparam logic [3:0] S_POST    = 4'd7;
   localparam logic [3:0] S_SC_CHK  = 4'd8;
   localparam logic [3:0] S_SC_WR   = 4'd9;
   localparam logic [3:0] S_BLANK   = 4'd10;
   localparam logic [3:0] S_RESULT  = 4'd11;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.addr_sel  = ADR_CUR;
      cmd.wd_sel    = WD_ZERO;
      cmd.cur_op    = CUR_HOLD;
      cmd.idx_op    = IDX_HOLD;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADR_CLEAR;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.cls)
               CLS_READ: begin
                  cmd.mem_rd   = 1'b1;
                  cmd.addr_sel = ADR_ITEM;
                  state_in     = S_RESULT;
               end
               CLS_NL: begin
                  cmd.cur_op = CUR_NL;
                  state_in   = S_POST;
               end
               CLS_CR: begin
                  cmd.cur_op = CUR_CR;
                  state_in   = S_POST;
               end
               CLS_TAB: begin
                  cmd.cur_op = CUR_TAB;
                  state_in   = S_POST;
               end
               CLS_BS: begin
                  priority if (stat.guard) begin
                     state_in = S_RESULT;
                  end else if (stat.at_left) begin
                     cmd.cur_op = CUR_BS_UP;
                     state_in   = S_BS_SCAN;
                  end else begin
                     cmd.cur_op = CUR_DEC;
                     state_in   = S_BS_WR;
                  end
               end
               CLS_ZERO: state_in = S_RESULT;
               CLS_PRINT: begin
                  cmd.mem_wr   = 1'b1;
                  cmd.addr_sel = ADR_CUR;
                  cmd.wd_sel   = WD_CHAR;
                  cmd.cur_op   = CUR_INC;
                  state_in     = S_POST;
               end
               default: state_in = S_RESULT;
            endcase
         end
         S_BS_SCAN: begin
            if (stat.scan_go) begin
               cmd.mem_rd   = 1'b1;
               cmd.addr_sel = ADR_CURM1;
               state_in     = S_BS_WAIT;
            end else begin
               state_in = S_BS_FIX;
            end
         end
         S_BS_WAIT: begin
            if (stat.blank_hit) begin
               cmd.cur_op = CUR_DEC;
               state_in   = S_BS_SCAN;
            end else begin
               state_in = S_BS_FIX;
            end
         end
         S_BS_FIX: begin
            if (stat.col_eq_end) cmd.cur_op = CUR_DEC;
            state_in = S_BS_WR;
         end
         S_BS_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADR_CUR;
            cmd.wd_sel   = WD_BLANK;
            state_in     = S_POST;
         end
         S_POST: begin
            cmd.cur_op = CUR_POST;
            if (stat.scroll_need) begin
               cmd.idx_op = IDX_INIT;
               state_in   = S_SC_CHK;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_SC_CHK: begin
            priority if (stat.i_live && stat.j_live) begin
               cmd.mem_rd   = 1'b1;
               cmd.addr_sel = ADR_SCAN;
               state_in     = S_SC_WR;
            end else if (stat.i_live) begin
               cmd.idx_op = IDX_NEXTI;
            end else begin
               cmd.idx_op = IDX_BLINIT;
               state_in   = S_BLANK;
            end
         end
         S_SC_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADR_SCANUP;
            cmd.wd_sel   = WD_COPY;
            cmd.idx_op   = IDX_NEXTJ;
            state_in     = S_SC_CHK;
         end
         S_BLANK: begin
            if (stat.j_live) begin
               cmd.mem_wr   = 1'b1;
               cmd.addr_sel = ADR_BLANK;
               cmd.wd_sel   = WD_BLANK;
               cmd.idx_op   = IDX_NEXTJ;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[rtl/text_window_char_writer.sv]
// Steps after a request beat is accepted: decode; a left-border backspace scans blank cells
//   back from the right edge; a scroll moves each cell up a row and blanks the bottom row;
//   then the result beat is registered. One item at a time: the next request beat is taken
//   only after the result is registered.
// Reset (synchronous, active high) restores registers and cursor, then clears all
//   ROWS*COLS cells, one per cycle, with the input stalled throughout.
module text_window_char_writer
   import twcw_pkg::*;
#(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   // request beats
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [7:0]           req_char_code,
   input  logic [10:0]          req_cell_addr,
   // response beats
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [4:0]           rsp_cursor_row,
   output logic [6:0]           rsp_cursor_col,
   output logic [15:0]          rsp_cell_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: decodes the beat and walks backspace scans and scrolls
   twcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // cursor, window registers, cell buffer and the result register
   twcw_dpath #(.ROWS(ROWS), .COLS(COLS)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_cell_addr  (req_cell_addr),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cell_data  (rsp_cell_data),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

[bench/twcw_checker.sv]
module twcw_checker
   import twcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [7:0]           req_char_code,
   input  logic [10:0]          req_cell_addr,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [4:0]           rsp_cursor_row,
   input  logic [6:0]           rsp_cursor_col,
   input  logic [15:0]          rsp_cell_data,
   output int                   fail_count,
   output int                   pending
);
   localparam int NROWS  = 25;
   localparam int NCOLS  = 80;
   localparam int NCELLS = NROWS * NCOLS;

   typedef struct packed {
      logic [4:0]  row;
      logic [6:0]  col;
      logic [15:0] data;
   } cursor_beat_type;

   cursor_beat_type cursor_q[$];
   logic [15:0] cells[NCELLS];
   logic [4:0]  w_srow, w_erow, row;
   logic [6:0]  w_scol, w_ecol, col;
   logic [15:0] attr;
   logic [7:0]  tab_code, bs_code;

   function automatic logic [15:0] cell_get(int unsigned a);
      return (a < NCELLS) ? cells[a] : 16'h0;
   endfunction

   task automatic cell_set(int unsigned a, logic [15:0] v);
      if (a < NCELLS) cells[a] = v;
   endtask

   task automatic put_code(logic [7:0] c);
      int unsigned i, j;
      logic [15:0] cv;
      if (c == CH_NL) begin
         col = w_scol;
         row = row + 5'd1;
      end else if (c == CH_CR) begin
         col = w_scol;
      end else if (c == tab_code) begin
         col = ((col / 7'd4) + 7'd1) * 7'd4;
      end else if (c == bs_code) begin
         if (col == w_scol && row == w_srow + 5'd1) return;
         if (col == w_scol) begin
            row = row - 5'd1;
            col = w_ecol;
            while (col > w_scol) begin
               cv = cell_get(row * NCOLS + col - 1);
               if (cv[7:0] != CH_SPACE) break;
               col = col - 7'd1;
            end
            if (col == w_ecol) col = col - 7'd1;
         end else begin
            col = col - 7'd1;
         end
         cell_set(row * NCOLS + col, attr + CH_SPACE);
      end else if (c == 8'd0) begin
         return;
      end else begin
         cell_set(row * NCOLS + col, attr + c);
         col = col + 7'd1;
      end
      if (col >= w_ecol) begin
         col = w_scol;
         row = row + 5'd1;
      end
      if (row >= w_erow) begin
         row = w_erow - 5'd1;
         col = w_scol;
         for (i = w_srow + 2; i < w_erow; i++)
            for (j = w_scol; j < w_ecol; j++)
               cell_set(i * NCOLS + j - NCOLS, cell_get(i * NCOLS + j));
         for (j = w_scol; j < w_ecol; j++)
            cell_set(row * NCOLS + j, attr + CH_SPACE);
      end
   endtask

   always @(posedge clock) begin
      cursor_beat_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         w_srow = 5'd0; w_scol = 7'd0; w_erow = 5'd25; w_ecol = 7'd55;
         attr = ATTR_RST; tab_code = 8'd9; bs_code = 8'd8;
         row = 5'd0; col = 7'd0;
         for (int k = 0; k < NCELLS; k++) cells[k] = 16'h0;
         cursor_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_START_ROW: w_srow = csr_wdata[4:0];
               REG_START_COL: w_scol = csr_wdata[6:0];
               REG_END_ROW:   w_erow = csr_wdata[4:0];
               REG_END_COL:   w_ecol = csr_wdata[6:0];
               REG_ATTR_BASE: attr = csr_wdata;
               REG_TAB_CHAR:  tab_code = csr_wdata[7:0];
               REG_BS_CHAR:   bs_code = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want.data = 16'h0;
            if (req_cmd) want.data = cell_get(32'(req_cell_addr));
            else put_code(req_char_code);
            want.row = row;
            want.col = col;
            cursor_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_cursor_row, rsp_cursor_col, rsp_cell_data};
            if (cursor_q.size() == 0) begin
               $error("unexpected response beat");
               errs++;
            end else begin
               want = cursor_q.pop_front();
               if (got.row !== want.row) begin
                  $error("cursor_row exp %0d got %0d", want.row, got.row);
                  errs++;
               end
               if (got.col !== want.col) begin
                  $error("cursor_col exp %0d got %0d", want.col, got.col);
                  errs++;
               end
               if (got.data !== want.data) begin
                  $error("cell_data exp %h got %h", want.data, got.data);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= cursor_q.size();
      end
   end
endmodule

[bench/text_window_char_writer_tb.sv]
module text_window_char_writer_tb;
   import twcw_pkg::*;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = REG_START_ROW;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   logic                 req_valid = 0;
   logic                 req_stall;
   logic                 req_cmd = 0;
   logic [7:0]           req_char_code = 0;
   logic [10:0]          req_cell_addr = 0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   logic [4:0]           rsp_cursor_row;
   logic [6:0]           rsp_cursor_col;
   logic [15:0]          rsp_cell_data;
   int                   fail_count;
   int                   pending;
   int                   hold_off = 0;   // long receiver hold, cycles left
   logic [7:0]           tab_now = 8'd9;
   logic [7:0]           bs_now = 8'd8;

   always #4 clock = ~clock;

   text_window_char_writer dut (.*);
   twcw_checker chk (.*);

   // receiver: own stall pattern, plus a long hold when asked
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         case ($urandom_range(0, 3))
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) == 0);
            2: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // one request beat; held until accepted
   task automatic send_beat(logic cmd, logic [7:0] code, logic [10:0] addr);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_char_code <= code;
      req_cell_addr <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic go_idle(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // drain, let the block settle, then write a register
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      go_idle(1);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_TAB_CHAR) tab_now = val[7:0];
      if (idx == REG_BS_CHAR) bs_now = val[7:0];
   endtask

   // weighted code: mostly printable, with control codes mixed in
   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 19))
         0: return CH_NL;
         1: return CH_CR;
         2: return tab_now;
         3, 4: return bs_now;
         5: return 8'd0;
         6: return CH_SPACE;
         7: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(33, 126));
      endcase
   endfunction

   task automatic random_burst(int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 5) == 0)
            send_beat(1'b1, 8'($urandom), ($urandom_range(0, 9) == 0) ?
                      11'($urandom_range(0, 2047)) : 11'($urandom_range(0, 1999)));
         else
            send_beat(1'b0, pick_code(), 11'($urandom));
         if ($urandom_range(0, 3) == 0) go_idle(int'($urandom_range(1, 6)));
      end
   endtask

   initial begin
      int unsigned sr, er, sc, ec;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, controls, tab, backspace cases, reads, extremes
      send_beat(1'b0, 8'hFF, 11'd0);
      send_beat(1'b0, 8'h01, 11'd0);
      send_beat(1'b0, CH_SPACE, 11'd0);
      send_beat(1'b0, CH_SPACE, 11'd0);
      send_beat(1'b0, 8'd9, 11'd0);
      send_beat(1'b0, 8'd0, 11'd0);
      send_beat(1'b0, 8'd8, 11'd0);
      send_beat(1'b0, CH_CR, 11'd0);
      send_beat(1'b0, 8'd8, 11'd0);      // backspace above top row wraps
      send_beat(1'b0, CH_NL, 11'd0);
      send_beat(1'b0, CH_NL, 11'd0);
      send_beat(1'b0, 8'd8, 11'd0);      // left border scan
      send_beat(1'b0, CH_NL, 11'd0);
      send_beat(1'b0, 8'd8, 11'd0);      // left border scan
      send_beat(1'b1, 8'd0, 11'd0);
      send_beat(1'b1, 8'd0, 11'd1999);
      send_beat(1'b1, 8'd0, 11'd2047);   // past the buffer
      for (int k = 0; k < 60; k++) send_beat(1'b0, 8'(8'h41 + k % 26), 11'd0);

      csr_write(REG_ATTR_BASE, 16'hFFFF);
      csr_write(REG_TAB_CHAR, 16'd13);   // shadowed by carriage return
      csr_write(REG_BS_CHAR, 16'hFF);
      csr_write(REG_START_COL, 16'd79);
      csr_write(REG_END_COL, 16'd80);
      csr_write(REG_START_ROW, 16'd23);
      csr_write(REG_END_ROW, 16'd25);
      send_beat(1'b0, 8'h7E, 11'd0);
      send_beat(1'b0, 8'hFF, 11'd0);
      send_beat(1'b0, 8'hFF, 11'd0);
      send_beat(1'b0, CH_NL, 11'd0);
      send_beat(1'b0, CH_NL, 11'd0);

      // random phases over several windows; small windows keep scrolls short
      for (int ph = 0; ph < 12; ph++) begin
         sr = $urandom_range(0, 22);
         er = $urandom_range(sr + 2, (sr + 6 > 25) ? 25 : sr + 6);
         sc = $urandom_range(0, 70);
         ec = $urandom_range(sc + 2, (sc + 12 > 80) ? 80 : sc + 12);
         if (ph == 11) begin sr = 0; er = 25; sc = 0; ec = 80; end
         csr_write(REG_START_ROW, 16'(sr));
         csr_write(REG_END_ROW, 16'(er));
         csr_write(REG_START_COL, 16'(sc));
         csr_write(REG_END_COL, 16'(ec));
         csr_write(REG_ATTR_BASE, 16'($urandom));
         csr_write(REG_TAB_CHAR, (ph % 3 == 0) ? 16'($urandom_range(0, 255)) : 16'd9);
         csr_write(REG_BS_CHAR, (ph % 3 == 1) ? 16'($urandom_range(0, 255)) : 16'd8);
         if (ph == 3) hold_off <= 300;   // fill the block up behind a long hold
         random_burst(160);
         if (ph == 6) begin              // sender waits for everything to drain
            go_idle(1);
            while (pending != 0) @(posedge clock);
         end
      end
      csr_write(REG_ATTR_BASE, 16'h0000);
      random_burst(60);

      go_idle(1);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #100000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

[sim.f]
rtl/twcw_pkg.sv
rtl/twcw_ram.sv
rtl/twcw_dpath.sv
rtl/twcw_ctrl.sv
rtl/text_window_char_writer.sv
bench/twcw_checker.sv
bench/text_window_char_writer_tb.sv
